// ===== rtl/sem_pkg.sv =====
// Shared types and constants of the Sobel edge-magnitude block.
// No dependencies; every other file but sem_ram refers to it by scoped names.
package sem_pkg;

    localparam int CFG_W       = 11;
    localparam int ADDR_W      = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int GRAD_W      = 11;
    localparam int ABS_W       = 10;
    localparam int SQ_W        = 20;
    localparam int RAD_W       = 21;
    localparam int NUM_RES     = 4;
    localparam int MIN_SIZE    = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd600;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int RES_MAIN   = 0;
    localparam int RES_RIGHT  = 1;
    localparam int RES_BOTTOM = 2;
    localparam int RES_CORNER = 3;

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [NUM_RES-1:0]       mask;
    } t_job;

endpackage

// ===== rtl/sem_pix_if.sv =====
// Pixel input channel: valid/ready handshake carrying one pixel word.
// Depends on sem_pkg for field widths.
interface sem_pix_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::PIX_W-1:0] pixel;
    logic                      frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== rtl/sem_res_if.sv =====
// Result output channel: valid/ready handshake carrying one result word.
// Depends on sem_pkg for field widths.
interface sem_res_if;
    logic                        valid;
    logic                        ready;
    logic [sem_pkg::COORD_W-1:0] col;
    logic [sem_pkg::COORD_W-1:0] row_index;
    logic [sem_pkg::PIX_W-1:0]   edge_res;
    logic                        last;
    logic                        frame_done;

    modport source (output valid, output col, output row_index, output edge_res,
                    output last, output frame_done, input ready);
    modport sink   (input valid, input col, input row_index, input edge_res,
                    input last, input frame_done, output ready);
endinterface

// ===== rtl/sem_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sem_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on sem_pkg for the job type and depth.
module sem_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sem_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output sem_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int QAW = $clog2(sem_pkg::QUEUE_DEPTH);

    sem_pkg::t_job r_mem [sem_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(sem_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_job;
                r_wptr        <= (r_wptr == QAW'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                                 : r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_rptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");

endmodule

// ===== rtl/sem_front.sv =====
// Front part: accepts pixels, tracks raster position, runs the line store and
// 3x3 window, forms Gx/Gy and the result mask. Uses sem_pkg, sem_pix_if, sem_ram.
module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sem_pkg::CFG_W-1:0]   i_width,
    input  logic [sem_pkg::CFG_W-1:0]   i_height,
    sem_pix_if.sink                     i_pix,
    input  logic                        i_full,
    output logic                        o_push,
    output sem_pkg::t_job               o_job
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = (XW + 1 > sem_pkg::CFG_W) ? XW + 1 : sem_pkg::CFG_W;
    localparam int HW = (YW + 1 > sem_pkg::CFG_W) ? YW + 1 : sem_pkg::CFG_W;
    localparam int PW = sem_pkg::PIX_W;
    localparam int SW = PW + 2;

    typedef enum logic {S_IDLE, S_CALC} t_state;

    t_state                  r_state;
    logic [XW-1:0]           r_col;
    logic [YW-1:0]           r_row;
    logic [XW-1:0]           r_x;
    logic [YW-1:0]           r_y;
    logic [PW-1:0]           r_b;
    logic                    r_inter;
    logic [sem_pkg::NUM_RES-1:0] r_mask;
    logic [PW-1:0]           r_win [6];

    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;
    logic [WW-1:0] col0;
    logic [WW-1:0] col1;
    logic [HW-1:0] row0;
    logic [HW-1:0] row1;
    logic          accept;
    logic [sem_pkg::NUM_RES-1:0] n_mask;
    logic          n_inter;
    logic [2*PW-1:0] ram_rdata;
    logic [PW-1:0] pix_t;
    logic [PW-1:0] pix_m;
    logic [SW-1:0] sum_l;
    logic [SW-1:0] sum_r;
    logic [SW-1:0] sum_t;
    logic [SW-1:0] sum_b;
    logic signed [sem_pkg::GRAD_W-1:0] gx;
    logic signed [sem_pkg::GRAD_W-1:0] gy;

    always_comb begin
        logic [WW-1:0] w_raw;
        logic [HW-1:0] h_raw;
        w_raw = WW'(i_width);
        h_raw = HW'(i_height);
        if (w_raw < WW'(sem_pkg::MIN_SIZE)) begin
            w_clamp = WW'(sem_pkg::MIN_SIZE);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (h_raw < HW'(sem_pkg::MIN_SIZE)) begin
            h_clamp = HW'(sem_pkg::MIN_SIZE);
        end else if (h_raw > HW'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = h_raw;
        end
    end

    always_comb begin
        logic first_col;
        logic first_row;
        logic right;
        logic bottom;
        col0 = i_pix.frame_start ? '0 : WW'(r_col);
        row0 = i_pix.frame_start ? '0 : HW'(r_row);
        if (col0 >= w_clamp) begin
            col0 = '0;
            row0 = row0 + HW'(1);
        end
        if (row0 >= h_clamp) begin
            row0 = '0;
        end
        col1 = col0 + WW'(1);
        row1 = row0;
        if (col1 >= w_clamp) begin
            col1 = '0;
            row1 = row0 + HW'(1);
            if (row1 >= h_clamp) begin
                row1 = '0;
            end
        end
        first_col = (col0 == '0);
        first_row = (row0 == '0);
        right     = (col0 == w_clamp - WW'(1));
        bottom    = (row0 == h_clamp - HW'(1));
        n_mask[sem_pkg::RES_MAIN]   = !first_col && !first_row;
        n_mask[sem_pkg::RES_RIGHT]  = !first_col && !first_row && right;
        n_mask[sem_pkg::RES_BOTTOM] = !first_col && bottom;
        n_mask[sem_pkg::RES_CORNER] = !first_col && bottom && right;
        n_inter = (col0 >= WW'(2)) && (row0 >= HW'(2));
    end

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE) && !i_full;

    sem_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_x),
        .i_wdata ({pix_m, r_b}),
        .i_raddr (col0[XW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign pix_t = ram_rdata[2*PW-1:PW];
    assign pix_m = ram_rdata[PW-1:0];

    assign sum_l = SW'(r_win[3]) + {1'b0, r_win[4], 1'b0} + SW'(r_win[5]);
    assign sum_r = SW'(pix_t) + {1'b0, pix_m, 1'b0} + SW'(r_b);
    assign sum_t = SW'(r_win[3]) + {1'b0, r_win[0], 1'b0} + SW'(pix_t);
    assign sum_b = SW'(r_win[5]) + {1'b0, r_win[2], 1'b0} + SW'(r_b);
    assign gx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
    assign gy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});

    assign o_push    = (r_state == S_CALC) && (r_mask != '0);
    assign o_job.x   = sem_pkg::COORD_W'(r_x);
    assign o_job.y   = sem_pkg::COORD_W'(r_y);
    assign o_job.gx  = r_inter ? gx : '0;
    assign o_job.gy  = r_inter ? gy : '0;
    assign o_job.mask = r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x     <= col0[XW-1:0];
                        r_y     <= row0[YW-1:0];
                        r_b     <= i_pix.pixel;
                        r_mask  <= n_mask;
                        r_inter <= n_inter;
                        r_col   <= col1[XW-1:0];
                        r_row   <= row1[YW-1:0];
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_win[3] <= r_win[0];
                    r_win[4] <= r_win[1];
                    r_win[5] <= r_win[2];
                    r_win[0] <= pix_t;
                    r_win[1] <= pix_m;
                    r_win[2] <= r_b;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sem_back.sv =====
// Back part: pops jobs, squares the gradients, takes an 8-step integer root and
// sends the job's results one word at a time. Uses sem_pkg and sem_res_if.
module sem_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sem_pkg::t_job i_job,
    output logic          o_pop,
    sem_res_if.source     o_res
);

    localparam int CW = sem_pkg::COORD_W;
    localparam int AW = sem_pkg::ABS_W;
    localparam int PW = sem_pkg::PIX_W;
    localparam int NR = sem_pkg::NUM_RES;

    typedef enum logic [2:0] {S_POP, S_SQR, S_SUM, S_ROOT, S_EMIT} t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_x;
    logic [CW-1:0]                   r_y;
    logic signed [sem_pkg::GRAD_W-1:0] r_gx;
    logic signed [sem_pkg::GRAD_W-1:0] r_gy;
    logic [NR-1:0]                   r_mask;
    logic [sem_pkg::SQ_W-1:0]        r_sqx;
    logic [sem_pkg::SQ_W-1:0]        r_sqy;
    logic [sem_pkg::RAD_W-1:0]       r_rad;
    logic [PW-1:0]                   r_root;
    logic [PW-1:0]                   r_bit;
    logic                            r_ovalid;
    logic [CW-1:0]                   r_ocol;
    logic [CW-1:0]                   r_orow;
    logic [PW-1:0]                   r_oedge;
    logic                            r_olast;
    logic                            r_odone;

    logic [AW-1:0]     ax;
    logic [AW-1:0]     ay;
    logic [PW-1:0]     trial;
    logic [2*PW-1:0]   trial_sq;
    logic [NR-1:0]     sel;
    logic [NR-1:0]     rest;
    logic              load;

    assign ax       = r_gx[sem_pkg::GRAD_W-1] ? AW'(-r_gx) : AW'(r_gx);
    assign ay       = r_gy[sem_pkg::GRAD_W-1] ? AW'(-r_gy) : AW'(r_gy);
    assign trial    = r_root | r_bit;
    assign trial_sq = {{PW{1'b0}}, trial} * {{PW{1'b0}}, trial};
    assign sel      = r_mask & (~r_mask + NR'(1));
    assign rest     = r_mask & ~sel;
    assign load     = (r_state == S_EMIT) && (!r_ovalid || o_res.ready);
    assign o_pop    = (r_state == S_POP) && !i_empty;

    assign o_res.valid      = r_ovalid;
    assign o_res.col        = r_ocol;
    assign o_res.row_index  = r_orow;
    assign o_res.edge_res   = r_oedge;
    assign o_res.last       = r_olast;
    assign o_res.frame_done = r_odone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_POP;
            r_ovalid <= 1'b0;
            r_mask   <= '0;
            r_bit    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_ocol   <= (sel[sem_pkg::RES_RIGHT] || sel[sem_pkg::RES_CORNER]) ? r_x
                            : r_x - CW'(1);
                r_orow   <= (sel[sem_pkg::RES_BOTTOM] || sel[sem_pkg::RES_CORNER]) ? r_y
                            : r_y - CW'(1);
                r_oedge  <= sel[sem_pkg::RES_MAIN] ? r_root : '0;
                r_olast  <= (rest == '0);
                r_odone  <= sel[sem_pkg::RES_CORNER];
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_POP: begin
                    if (!i_empty) begin
                        r_x     <= i_job.x;
                        r_y     <= i_job.y;
                        r_gx    <= i_job.gx;
                        r_gy    <= i_job.gy;
                        r_mask  <= i_job.mask;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_sqx   <= {{AW{1'b0}}, ax} * {{AW{1'b0}}, ax};
                    r_sqy   <= {{AW{1'b0}}, ay} * {{AW{1'b0}}, ay};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= {1'b0, r_sqx} + {1'b0, r_sqy};
                    r_root  <= '0;
                    r_bit   <= {1'b1, {(PW-1){1'b0}}};
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if ({{(sem_pkg::RAD_W-2*PW){1'b0}}, trial_sq} <= r_rad) begin
                        r_root <= trial;
                    end
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_mask <= rest;
                        if (rest == '0) begin
                            r_state <= S_POP;
                        end
                    end
                end
                default: begin
                    r_state <= S_POP;
                end
            endcase
        end
    end

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_mask != '0)) else $error("emit with empty mask");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odone) |-> r_olast) else $error("frame end not last word");
    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_bit)) else $error("root bit not one-hot");

endmodule

// ===== rtl/sobel_edge_magnitude_top.sv =====
// Top level of the Sobel 3x3 gradient-magnitude block: APB registers and
// wiring of front, queue and back. Uses sem_pkg, both channel interfaces.
//
// Pixels arrive in raster order; each word yields zero to four result words,
// each carrying its own column and row, with the one-pixel border forced to
// zero and the last row closed out by the pixels of that row. The front takes
// no new pixel until its line-store read is followed by the write of the same
// column, nor while the queue is full. A pixel in row 0 or column 0 produces
// no results and no job; any other job passes the back's pop, square, sum and
// 8-step bit-serial square root, then sends one result word at a time as the
// output takes them, before the back pops the next job. A two-entry queue
// lets front and back stall apart. Line stores need no clearing after reset.
// The user must write image_width and image_height only while the block is
// idle; the block itself does not enforce this.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sem_pix_if.sink                            i_pix,
    sem_res_if.source                          o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sem_pkg::ADDR_W-1:0]         paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [sem_pkg::CFG_W-1:0] r_width;
    logic [sem_pkg::CFG_W-1:0] r_height;
    logic                      cfg_wr;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    sem_pkg::t_job             q_in;
    sem_pkg::t_job             q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_RESET;
            r_height <= sem_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[sem_pkg::REG_SEL_BIT])
                sem_pkg::REG_WIDTH:  r_width  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_HEIGHT: r_height <= pwdata[sem_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[sem_pkg::REG_SEL_BIT])
            sem_pkg::REG_WIDTH:  prdata = sem_pkg::APB_DATA_W'(r_width);
            sem_pkg::REG_HEIGHT: prdata = sem_pkg::APB_DATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_pix    (i_pix),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_job    (q_in)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    sem_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (q_out),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// ===== tb/sv/sobel_edge_magnitude_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_top: streams pixel frames of many sizes,
// predicts every result word in-bench and checks each one in order under idle and stall.
// Depends on sem_pkg, sem_pix_if, sem_res_if and the block's top level.
module sobel_edge_magnitude_top_test;

    localparam int MAX_DIM      = 1024;
    localparam int DRAIN_CYCLES = 64;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic [sem_pkg::PIX_W-1:0] pixel;
        logic                      frame_start;
    } t_pix_word;

    typedef struct packed {
        logic [sem_pkg::COORD_W-1:0] col;
        logic [sem_pkg::COORD_W-1:0] row_index;
        logic [sem_pkg::PIX_W-1:0]   edge_res;
        logic                        last;
        logic                        frame_done;
    } t_res_word;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sem_pkg::ADDR_W-1:0]     paddr;
    logic [sem_pkg::APB_DATA_W-1:0] pwdata;
    logic [sem_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    sem_pix_if pix_bus ();
    sem_res_if res_bus ();

    sobel_edge_magnitude_top #(
        .MAX_WIDTH (MAX_DIM),
        .MAX_HEIGHT(MAX_DIM)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_bus),
        .o_res  (res_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic [sem_pkg::PIX_W-1:0] row_two [MAX_DIM];
    logic [sem_pkg::PIX_W-1:0] row_one [MAX_DIM];
    logic [sem_pkg::PIX_W-1:0] win [6];
    int                        col_pos;
    int                        row_pos;
    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;

    t_pix_word pix_pending[$];
    t_res_word expected_words[$];
    t_pix_word next_word;
    t_res_word seen_word;
    t_res_word want_word;

    int   pixels_queued;
    int   pixels_sent;
    int   words_checked;
    int   error_count;
    int   print_count;
    int   quiet_cycles;
    int   src_idle;
    int   snk_idle;
    int   hold_left;
    logic hold_go;
    logic hold_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input logic [sem_pkg::CFG_W-1:0] v);
        if (v < sem_pkg::MIN_SIZE) return sem_pkg::MIN_SIZE;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int root_sat(input int v);
        int r;
        r = 0;
        for (int step = 128; step > 0; step = step >> 1) begin
            if ((r + step) * (r + step) <= v) r = r + step;
        end
        return r;
    endfunction

    function automatic t_res_word make_word(input int c, input int r, input int v,
                                            input logic done);
        t_res_word rw;
        rw.col        = c[sem_pkg::COORD_W-1:0];
        rw.row_index  = r[sem_pkg::COORD_W-1:0];
        rw.edge_res   = v[sem_pkg::PIX_W-1:0];
        rw.last       = 1'b0;
        rw.frame_done = done;
        return rw;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (print_count < MAX_PRINTS) begin
            print_count++;
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic predict_pixel(input logic [sem_pkg::PIX_W-1:0] pix, input logic fs);
        int        w;
        int        h;
        int        x;
        int        y;
        int        t;
        int        m;
        int        b;
        int        gx;
        int        gy;
        int        mag;
        t_res_word batch[$];
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        b = int'(pix);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;
        t = int'(row_two[x]);
        m = int'(row_one[x]);
        row_two[x] = row_one[x];
        row_one[x] = pix;
        mag = 0;
        if (x >= 2 && y >= 2) begin
            gx = (int'(win[3]) + 2 * int'(win[4]) + int'(win[5])) - (t + 2 * m + b);
            gy = (int'(win[3]) + 2 * int'(win[0]) + t)
                 - (int'(win[5]) + 2 * int'(win[2]) + b);
            mag = root_sat(gx * gx + gy * gy);
        end
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = t[sem_pkg::PIX_W-1:0];
        win[1] = m[sem_pkg::PIX_W-1:0];
        win[2] = pix;
        if (y >= 1 && x >= 1) begin
            batch.push_back(make_word(x - 1, y - 1, mag, 1'b0));
            if (x == w - 1) batch.push_back(make_word(w - 1, y - 1, 0, 1'b0));
        end
        if (y == h - 1 && x >= 1) begin
            batch.push_back(make_word(x - 1, h - 1, 0, 1'b0));
            if (x == w - 1) batch.push_back(make_word(w - 1, h - 1, 0, 1'b1));
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_words.push_back(batch[i]);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                predict_pixel(pix_bus.pixel, pix_bus.frame_start);
                pixels_sent++;
            end
            if (!(pix_bus.valid && !pix_bus.ready)) begin
                if (pix_pending.size() > 0 && $urandom_range(99) >= src_idle) begin
                    next_word = pix_pending.pop_front();
                    pix_bus.valid       <= 1'b1;
                    pix_bus.pixel       <= next_word.pixel;
                    pix_bus.frame_start <= next_word.frame_start;
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                seen_word.col        = res_bus.col;
                seen_word.row_index  = res_bus.row_index;
                seen_word.edge_res   = res_bus.edge_res;
                seen_word.last       = res_bus.last;
                seen_word.frame_done = res_bus.frame_done;
                words_checked++;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word col %0d row %0d edge %0d",
                        seen_word.col, seen_word.row_index, seen_word.edge_res));
                end else begin
                    want_word = expected_words.pop_front();
                    if (seen_word !== want_word) begin
                        report_mismatch($sformatf({"got col %0d row %0d edge %0d last %0b ",
                            "done %0b, want %0d %0d %0d %0b %0b"},
                            seen_word.col, seen_word.row_index, seen_word.edge_res,
                            seen_word.last, seen_word.frame_done,
                            want_word.col, want_word.row_index, want_word.edge_res,
                            want_word.last, want_word.frame_done));
                    end
                end
            end
            if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
                || (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer in %0d cycles, %0d words outstanding",
                     QUIET_LIMIT, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic read_size_reg(input logic reg_sel,
                                 output logic [sem_pkg::APB_DATA_W-1:0] data);
        logic [sem_pkg::ADDR_W-1:0] addr_v;
        addr_v = '0;
        addr_v[sem_pkg::REG_SEL_BIT] = reg_sel;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr_v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_size_reg(input logic reg_sel,
                                input logic [sem_pkg::APB_DATA_W-1:0] value);
        logic [sem_pkg::ADDR_W-1:0]     addr_v;
        logic [sem_pkg::APB_DATA_W-1:0] rd;
        addr_v = '0;
        addr_v[sem_pkg::REG_SEL_BIT] = reg_sel;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr_v;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == sem_pkg::REG_WIDTH) width_reg = value[sem_pkg::CFG_W-1:0];
        else height_reg = value[sem_pkg::CFG_W-1:0];
        read_size_reg(reg_sel, rd);
        if (rd[sem_pkg::CFG_W-1:0] !== value[sem_pkg::CFG_W-1:0]) begin
            report_mismatch($sformatf("register %0d reads %0d, written %0d",
                reg_sel, rd[sem_pkg::CFG_W-1:0], value[sem_pkg::CFG_W-1:0]));
        end
    endtask

    task automatic set_dims(input int w, input int h);
        set_size_reg(sem_pkg::REG_WIDTH, w);
        set_size_reg(sem_pkg::REG_HEIGHT, h);
    endtask

    task automatic set_idle(input int src_pct, input int snk_pct);
        @(posedge i_clk);
        src_idle <= src_pct;
        snk_idle <= snk_pct;
        @(negedge i_clk);
    endtask

    task automatic push_pixel(input logic [sem_pkg::PIX_W-1:0] pix, input logic fs);
        t_pix_word item;
        item.pixel       = pix;
        item.frame_start = fs;
        pix_pending.push_back(item);
        pixels_queued++;
    endtask

    task automatic queue_pixels(input int count, input int frame_len, input int noise_pct);
        logic                      fs;
        logic [sem_pkg::PIX_W-1:0] pix;
        for (int i = 0; i < count; i++) begin
            fs = (frame_len > 0 && i % frame_len == 0) || ($urandom_range(99) < noise_pct);
            if ($urandom_range(3) == 0) pix = $urandom_range(1) ? 8'hFF : 8'h00;
            else pix = 8'($urandom);
            push_pixel(pix, fs);
        end
    endtask

    task automatic wait_idle();
        while (pixels_sent != pixels_queued || expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [sem_pkg::APB_DATA_W-1:0] rd;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel       = '0;
        pix_bus.frame_start = 1'b0;
        res_bus.ready       = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        foreach (row_two[i]) begin
            row_two[i] = '0;
            row_one[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        col_pos       = 0;
        row_pos       = 0;
        width_reg     = sem_pkg::WIDTH_RESET;
        height_reg    = sem_pkg::HEIGHT_RESET;
        pixels_queued = 0;
        pixels_sent   = 0;
        words_checked = 0;
        error_count   = 0;
        print_count   = 0;
        quiet_cycles  = 0;
        src_idle      = 0;
        snk_idle      = 0;
        hold_left     = 0;
        hold_go       = 1'b0;
        hold_seen     = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_size_reg(sem_pkg::REG_WIDTH, rd);
        if (rd[sem_pkg::CFG_W-1:0] !== sem_pkg::WIDTH_RESET) begin
            report_mismatch("width register reset value");
        end
        read_size_reg(sem_pkg::REG_HEIGHT, rd);
        if (rd[sem_pkg::CFG_W-1:0] !== sem_pkg::HEIGHT_RESET) begin
            report_mismatch("height register reset value");
        end

        // smallest frame: saturating edge, abandoned frame, restart mid-frame, small gradient
        set_dims(0, 2);
        set_idle(0, 0);
        for (int i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'hFF : 8'h00, i == 0);
        for (int i = 0; i < 4; i++) push_pixel(8'h80, i == 0);
        for (int i = 0; i < 9; i++) push_pixel((i == 8) ? 8'h08 : 8'h00, i == 0);
        wait_idle();

        set_dims(7, 5);
        set_idle(83, 0);
        queue_pixels(40, 35, 0);
        wait_idle();

        set_dims(4, 3);
        set_idle(0, 83);
        queue_pixels(40, 12, 4);
        wait_idle();

        set_dims(9, 4);
        set_idle(38, 38);
        queue_pixels(72, 36, 3);
        @(posedge i_clk);
        hold_go <= ~hold_go;
        wait_idle();

        // shrink the frame mid-row so both position counters wrap
        set_dims(12, 6);
        set_idle(0, 0);
        queue_pixels(30, 72, 0);
        wait_idle();
        set_dims(5, 1);
        set_idle(0, 0);
        queue_pixels(20, 0, 0);
        wait_idle();

        $display("run covered %0d pixels and %0d result words, frames from 3x3 to 12x6,",
                 pixels_sent, words_checked);
        $display("with clamped sizes, mid-frame restarts and wraps, idle, stall and backpressure");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
